### src/stbx_pkg.sv
// ----------------------------------------------------------------------------
// stbx_pkg: shared types and constants
// Types and constants shared by the structure table string extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stbx_pkg;

	localparam int unsigned STRING_BUFFER = 64;

	localparam logic [7:0] CharLimit = 8'(STRING_BUFFER - 1);

	localparam logic [0:0] CfgTableLength    = 1'b0;
	localparam logic [0:0] CfgStructureCount = 1'b1;

	localparam logic [7:0] KindBios   = 8'h00;
	localparam logic [7:0] KindSystem = 8'h01;

	localparam logic [7:0] OffsetFirst  = 8'h04;
	localparam logic [7:0] OffsetSecond = 8'h05;
	localparam logic [7:0] OffsetThird  = 8'h08;

	localparam logic [2:0] FieldSystemBase = 3'd3;

	typedef struct packed {
		logic [2:0] mask;
		logic [7:0] ch;
		logic       fin;
		logic       kind_sys;
	} grp_t;

endpackage

`default_nettype wire

### src/stbx_walk.sv
// ----------------------------------------------------------------------------
// stbx_walk: structure table walker
// Holds the walk state and configuration, and works out from each accepted
// byte the group of results that it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stbx_walk (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              accept,
	input  wire  [7:0]       table_byte,
	input  wire              restart,
	input  wire              cfg_we,
	input  wire  [0:0]       cfg_index,
	input  wire  [15:0]      cfg_wdata,
	output stbx_pkg::grp_t   grp
);
	import stbx_pkg::*;

	logic [15:0] table_length_q, structure_count_q;
	logic [15:0] byte_offset_q, structures_done_q;
	logic [7:0]  pos_q, flen_q, kind_q, cur_num_q, chars_q;
	logic [7:0]  wanted_q [3];
	logic        prev_zero_q, in_str_q, finished_q, trunc_q;

	logic [15:0] e_off, e_sd, n_off, n_sd;
	logic [7:0]  e_pos, e_flen, e_kind, e_cur, e_chars;
	logic [7:0]  n_pos, n_flen, n_kind, n_cur, n_chars;
	logic [7:0]  e_wanted [3];
	logic [7:0]  n_wanted [3];
	logic        e_prev, e_in, e_fin, e_trunc;
	logic        n_prev, n_in, n_fin, n_trunc;
	logic        done;
	logic [2:0]  hit;
	logic [8:0]  pos_inc;
	grp_t        g;

	always_comb begin
		e_off   = restart ? 16'd0 : byte_offset_q;
		e_sd    = restart ? 16'd0 : structures_done_q;
		e_pos   = restart ? 8'd0 : pos_q;
		e_flen  = restart ? 8'd0 : flen_q;
		e_kind  = restart ? 8'd0 : kind_q;
		e_cur   = restart ? 8'd0 : cur_num_q;
		e_chars = restart ? 8'd0 : chars_q;
		e_prev  = restart ? 1'b0 : prev_zero_q;
		e_in    = restart ? 1'b0 : in_str_q;
		e_fin   = restart ? 1'b0 : finished_q;
		e_trunc = restart ? 1'b0 : trunc_q;
		for (int s = 0; s < 3; s++) begin
			e_wanted[s] = restart ? 8'd0 : wanted_q[s];
			hit[s] = (e_wanted[s] != 8'd0) && (e_wanted[s] == e_cur);
		end

		n_off = e_off; n_sd = e_sd; n_pos = e_pos; n_flen = e_flen; n_kind = e_kind;
		n_cur = e_cur; n_chars = e_chars; n_prev = e_prev; n_in = e_in;
		n_fin = e_fin; n_trunc = e_trunc;
		for (int s = 0; s < 3; s++) begin
			n_wanted[s] = e_wanted[s];
		end
		pos_inc = {1'b0, e_pos} + 9'd1;

		g.mask     = 3'b000;
		g.ch       = 8'd0;
		g.fin      = 1'b0;
		g.kind_sys = (e_kind != KindBios);

		done = e_fin || (e_off >= table_length_q) || (e_sd >= structure_count_q);
		if (done) begin
			n_fin = 1'b1;
		end else begin
			if (e_off != 16'hFFFF) begin
				n_off = e_off + 16'd1;
			end
			if (!e_in) begin
				if (e_pos == 8'd0) begin
					n_kind = table_byte;
					for (int s = 0; s < 3; s++) begin
						n_wanted[s] = 8'd0;
					end
				end else if (e_pos == 8'd1) begin
					n_flen = table_byte;
				end else if (e_kind == KindBios) begin
					if (e_pos == OffsetFirst) begin
						n_wanted[0] = table_byte;
					end else if (e_pos == OffsetSecond) begin
						n_wanted[1] = table_byte;
					end else if (e_pos == OffsetThird) begin
						n_wanted[2] = table_byte;
					end
				end else if (e_kind == KindSystem) begin
					if (e_pos == OffsetFirst) begin
						n_wanted[0] = table_byte;
					end else if (e_pos == OffsetSecond) begin
						n_wanted[1] = table_byte;
					end
				end
				if ((e_pos != 8'd0) && (pos_inc >= {1'b0, n_flen})) begin
					n_in    = 1'b1;
					n_cur   = 8'd1;
					n_chars = 8'd0;
					n_trunc = 1'b0;
					n_prev  = 1'b0;
					n_pos   = 8'd0;
				end else begin
					n_pos = pos_inc[7:0];
				end
			end else if (table_byte == 8'd0) begin
				if (e_prev) begin
					if (e_sd != 16'hFFFF) begin
						n_sd = e_sd + 16'd1;
					end
					n_in   = 1'b0;
					n_pos  = 8'd0;
					n_prev = 1'b0;
				end else begin
					if ((e_chars != 8'd0) && !e_trunc) begin
						g.mask = hit;
					end
					g.fin = 1'b1;
					if ((e_cur != 8'd0) && (e_cur != 8'hFF)) begin
						n_cur = e_cur + 8'd1;
					end else begin
						n_cur = 8'd0;
					end
					n_chars = 8'd0;
					n_trunc = 1'b0;
					n_prev  = 1'b1;
				end
			end else begin
				n_prev = 1'b0;
				if (e_chars < CharLimit) begin
					g.mask  = hit;
					g.ch    = table_byte;
					n_chars = e_chars + 8'd1;
				end else begin
					if (!e_trunc) begin
						g.mask = hit;
					end
					g.fin   = 1'b1;
					n_trunc = 1'b1;
				end
			end
		end
	end

	assign grp = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q    <= 16'd0;
			structure_count_q <= 16'd0;
			byte_offset_q     <= 16'd0;
			structures_done_q <= 16'd0;
			pos_q             <= 8'd0;
			flen_q            <= 8'd0;
			kind_q            <= 8'd0;
			cur_num_q         <= 8'd0;
			chars_q           <= 8'd0;
			prev_zero_q       <= 1'b0;
			in_str_q          <= 1'b0;
			finished_q        <= 1'b0;
			trunc_q           <= 1'b0;
			for (int s = 0; s < 3; s++) begin
				wanted_q[s] <= 8'd0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgTableLength:    table_length_q <= cfg_wdata;
					CfgStructureCount: structure_count_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				byte_offset_q     <= n_off;
				structures_done_q <= n_sd;
				pos_q             <= n_pos;
				flen_q            <= n_flen;
				kind_q            <= n_kind;
				cur_num_q         <= n_cur;
				chars_q           <= n_chars;
				prev_zero_q       <= n_prev;
				in_str_q          <= n_in;
				finished_q        <= n_fin;
				trunc_q           <= n_trunc;
				for (int s = 0; s < 3; s++) begin
					wanted_q[s] <= n_wanted[s];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && !(accept && restart) |=> finished_q)
		else $error("walk left the finished state without a restart");
	a_chars_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		chars_q <= CharLimit)
		else $error("character count passed the buffer limit");
	a_no_result_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done |-> g.mask == 3'b000)
		else $error("result produced after the walk finished");
`endif

endmodule

`default_nettype wire

### src/stbx_out.sv
// ----------------------------------------------------------------------------
// stbx_out: result register and serialiser
// Registers the group of results of one byte and hands them out one item
// per cycle while the receiver is ready, in field order.
// ----------------------------------------------------------------------------
`default_nettype none

module stbx_out (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  wire stbx_pkg::grp_t  grp,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           field_id,
	output logic [7:0]           char_code,
	output logic                 string_end,
	output logic                 last_in_run
);
	import stbx_pkg::*;

	logic [2:0] mask_q;
	logic [7:0] ch_q;
	logic       fin_q, kind_sys_q;
	logic [2:0] sel;
	logic [2:0] slot;
	logic       take;

	always_comb begin
		sel  = 3'b000;
		slot = 3'd0;
		if (mask_q[0]) begin
			sel = 3'b001; slot = 3'd0;
		end else if (mask_q[1]) begin
			sel = 3'b010; slot = 3'd1;
		end else if (mask_q[2]) begin
			sel = 3'b100; slot = 3'd2;
		end
	end

	assign out_valid   = (mask_q != 3'b000);
	assign take        = out_valid && out_ready;
	assign last_in_run = ((mask_q & ~sel) == 3'b000);
	assign can_load    = !out_valid || (take && last_in_run);
	assign field_id    = kind_sys_q ? (FieldSystemBase + slot) : slot;
	assign char_code   = ch_q;
	assign string_end  = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
		end else if (load) begin
			mask_q <= grp.mask;
		end else if (take) begin
			mask_q <= mask_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q       <= grp.ch;
			fin_q      <= grp.fin;
			kind_sys_q <= grp.kind_sys;
		end
	end

`ifndef SYNTHESIS
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result group overwritten before it was drained");
	a_group_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && (grp.mask != 3'b000) |=> out_valid)
		else $error("loaded result group not presented");
	a_end_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> char_code == 8'd0)
		else $error("end marker carries a character");
`endif

endmodule

`default_nettype wire

### src/smbios_table_string_extractor.sv
// ----------------------------------------------------------------------------
// smbios_table_string_extractor: structure table string extractor
// Walks the structure table byte by byte and streams the characters of the
// BIOS vendor, version and date strings and the system manufacturer and
// product strings, each tagged with its field.
//
// Usage: write table_length and structure_count through the write port while
// the block is idle, then send the table bytes on the input channel, with
// restart set on the first byte of each table. Results leave on the output
// channel, one item per character or end marker; last_in_run flags the final
// result caused by one byte. A byte causes zero to three results.
// Latency: a result appears on the cycle after its byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver is ready; a byte with more results stalls the input until
// its last result leaves, as the single result register drains one per cycle.
// Reset clears the configuration, the walk state and the result register's mask.
// When the receiver stalls, the result is held and a new byte is taken only
// once the last pending result of the previous byte is leaving.
// ----------------------------------------------------------------------------
`default_nettype none

module smbios_table_string_extractor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  table_byte,
	input  wire         restart,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  field_id,
	output logic [7:0]  char_code,
	output logic        string_end,
	output logic        last_in_run,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_wdata
);
	import stbx_pkg::*;

	grp_t grp;
	logic accept;
	logic can_load;

	assign in_ready = can_load;
	assign accept   = in_valid && can_load;

	stbx_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.table_byte (table_byte),
		.restart    (restart),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.grp        (grp)
	);

	stbx_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.grp         (grp),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_id    (field_id),
		.char_code   (char_code),
		.string_end  (string_end),
		.last_in_run (last_in_run)
	);

endmodule

`default_nettype wire

### bench/smbios_table_string_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smbios_table_string_extractor_test: structure table string extractor bench
// Sends hand-built and random structure tables through the byte channel, keeps
// its own model of the table walk to predict every character and end marker,
// and checks each output item in order. Both channels idle at random, and the
// receiver holds off for a long stretch once so that the block fills and
// stalls its input.
// ----------------------------------------------------------------------------

module smbios_table_string_extractor_test;

	import stbx_pkg::*;

	localparam int WatchdogLimit = 3000;

	typedef struct packed {
		logic [2:0] field;
		logic [7:0] ch;
		logic       fin;
		logic       last;
	} char_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  table_byte = 8'h00;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  field_id;
	logic [7:0]  char_code;
	logic        string_end;
	logic        last_in_run;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = CfgTableLength;
	logic [15:0] cfg_wdata = 16'h0000;

	char_item_t  expected_chars[$];
	logic [7:0]  table_bytes[$];
	char_item_t  seen_item;
	char_item_t  want_item;
	bit          calm = 1'b0;
	logic        hold_out = 1'b0;
	int          mismatches = 0;
	int          results_checked = 0;
	int          bytes_sent = 0;
	int          tables_sent = 0;
	int          quiet_cycles = 0;

	// Walk model: configuration and state.
	logic [15:0] table_len_cfg;
	logic [15:0] struct_cnt_cfg;
	logic [15:0] offset_q;
	logic [15:0] structs_q;
	logic [7:0]  pos_q;
	logic [7:0]  flen_q;
	logic [7:0]  kind_q;
	logic [7:0]  want_q[3];
	logic [7:0]  str_num_q;
	logic [7:0]  str_chars_q;
	logic        zero_seen_q;
	logic        in_strings_q;
	logic        stopped_q;
	logic        cut_q;

	smbios_table_string_extractor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.table_byte (table_byte),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.field_id   (field_id),
		.char_code  (char_code),
		.string_end (string_end),
		.last_in_run(last_in_run),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #6 clk = ~clk;

	task automatic clear_walk;
		int i;
		offset_q = '0;
		structs_q = '0;
		pos_q = '0;
		flen_q = '0;
		kind_q = '0;
		for (i = 0; i < 3; i++) want_q[i] = '0;
		str_num_q = '0;
		str_chars_q = '0;
		zero_seen_q = 1'b0;
		in_strings_q = 1'b0;
		stopped_q = 1'b0;
		cut_q = 1'b0;
	endtask

	function automatic char_item_t make_char(int slot, logic [7:0] ch, logic fin);
		char_item_t item;
		item.field = (kind_q == KindBios) ? 3'(slot) : FieldSystemBase + 3'(slot);
		item.ch = ch;
		item.fin = fin;
		item.last = 1'b0;
		return item;
	endfunction

	task automatic walk_table_byte(input logic [7:0] b, input logic r);
		char_item_t items[3];
		int n;
		int p;
		int slot;
		bit hit;
		n = 0;
		if (r) clear_walk();
		if (stopped_q || offset_q >= table_len_cfg || structs_q >= struct_cnt_cfg) begin
			stopped_q = 1'b1;
			return;
		end
		if (offset_q != 16'hFFFF) offset_q = offset_q + 16'd1;
		if (!in_strings_q) begin
			p = pos_q;
			if (p == 0) begin
				kind_q = b;
				for (slot = 0; slot < 3; slot++) want_q[slot] = '0;
			end else if (p == 1) begin
				flen_q = b;
			end else if (kind_q == KindBios || kind_q == KindSystem) begin
				if (p == OffsetFirst) want_q[0] = b;
				else if (p == OffsetSecond) want_q[1] = b;
				else if (p == OffsetThird && kind_q == KindBios) want_q[2] = b;
			end
			if (p >= 1 && p + 1 >= int'(flen_q)) begin
				in_strings_q = 1'b1;
				str_num_q = 8'd1;
				str_chars_q = '0;
				cut_q = 1'b0;
				zero_seen_q = 1'b0;
				pos_q = '0;
			end else begin
				pos_q = 8'(p + 1);
			end
			return;
		end
		if (b == 8'h00) begin
			if (zero_seen_q) begin
				if (structs_q != 16'hFFFF) structs_q = structs_q + 16'd1;
				in_strings_q = 1'b0;
				pos_q = '0;
				zero_seen_q = 1'b0;
				return;
			end
			for (slot = 0; slot < 3; slot++) begin
				hit = want_q[slot] != 8'd0 && want_q[slot] == str_num_q;
				if (hit && str_chars_q != 8'd0 && !cut_q) begin
					items[n] = make_char(slot, 8'h00, 1'b1);
					n++;
				end
			end
			if (str_num_q != 8'd0 && str_num_q != 8'hFF) str_num_q = str_num_q + 8'd1;
			else str_num_q = 8'd0;
			str_chars_q = '0;
			cut_q = 1'b0;
			zero_seen_q = 1'b1;
		end else begin
			zero_seen_q = 1'b0;
			for (slot = 0; slot < 3; slot++) begin
				hit = want_q[slot] != 8'd0 && want_q[slot] == str_num_q;
				if (hit && str_chars_q < CharLimit) begin
					items[n] = make_char(slot, b, 1'b0);
					n++;
				end else if (hit && !cut_q) begin
					items[n] = make_char(slot, 8'h00, 1'b1);
					n++;
				end
			end
			if (str_chars_q < CharLimit) str_chars_q = str_chars_q + 8'd1;
			else cut_q = 1'b1;
		end
		for (slot = 0; slot < n; slot++) begin
			items[slot].last = (slot == n - 1);
			expected_chars.push_back(items[slot]);
		end
	endtask

	// Checks every output item against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_item = '{field_id, char_code, string_end, last_in_run};
			if (expected_chars.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected item: field %0d char %h end %b last %b",
						field_id, char_code, string_end, last_in_run);
				mismatches++;
			end else begin
				want_item = expected_chars.pop_front();
				if (want_item != seen_item) begin
					if (mismatches < 10)
						$display("mismatch: expected field %0d char %h end %b last %b, %s %0d %h %b %b",
							want_item.field, want_item.ch, want_item.fin, want_item.last,
							"got", field_id, char_code, string_end, last_in_run);
					mismatches++;
				end
			end
			results_checked++;
		end
	end

	always @(posedge clk)
		out_ready <= !hold_out && (calm || $urandom_range(0, 99) >= 7);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("smbios_table_string_extractor_test NOT OK");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic r);
		while (!calm && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		table_byte <= b;
		restart <= r;
		do @(posedge clk); while (!in_ready);
		walk_table_byte(b, r);
		bytes_sent++;
	endtask

	task automatic send_table(input int restart_pct);
		int i;
		for (i = 0; i < table_bytes.size(); i++)
			send_byte(table_bytes[i], i == 0 || $urandom_range(0, 99) < restart_pct);
		in_valid <= 1'b0;
		table_bytes.delete();
		tables_sent++;
	endtask

	task automatic wait_idle;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] len_val, input logic [15:0] cnt_val);
		cfg_we <= 1'b1;
		cfg_index <= CfgTableLength;
		cfg_wdata <= len_val;
		@(posedge clk);
		table_len_cfg = len_val;
		cfg_index <= CfgStructureCount;
		cfg_wdata <= cnt_val;
		@(posedge clk);
		struct_cnt_cfg = cnt_val;
		cfg_we <= 1'b0;
	endtask

	task automatic add_header(input logic [7:0] kind, input int flen,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		int p;
		table_bytes.push_back(kind);
		table_bytes.push_back(8'(flen));
		for (p = 2; p < flen; p++) begin
			if (p == OffsetFirst) table_bytes.push_back(a);
			else if (p == OffsetSecond) table_bytes.push_back(b);
			else if (p == OffsetThird) table_bytes.push_back(c);
			else table_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// A slash in the text separates strings; an empty text gives no strings.
	task automatic add_strings(input string text);
		int i;
		for (i = 0; i < text.len(); i++)
			table_bytes.push_back(text[i] == 8'h2F ? 8'h00 : text[i]);
		table_bytes.push_back(8'h00);
		if (text.len() != 0) table_bytes.push_back(8'h00);
	endtask

	task automatic add_random_string(input int len);
		int i;
		for (i = 0; i < len; i++) table_bytes.push_back(8'($urandom_range(1, 255)));
		table_bytes.push_back(8'h00);
	endtask

	task automatic test_after_reset;
		table_bytes.push_back(8'h00);
		table_bytes.push_back(8'hFF);
		table_bytes.push_back(8'hA5);
		table_bytes.push_back(8'h5A);
		send_table(50);
		wait_idle();
	endtask

	task automatic test_bios_and_system;
		set_config(16'hFFFF, 16'hFFFF);
		add_header(KindBios, 9, 8'd1, 8'd2, 8'd3);
		add_strings("V/Rx/D");
		add_header(KindSystem, 6, 8'd1, 8'd1, 8'd0);
		add_strings("M");
		send_table(0);
		wait_idle();
	endtask

	task automatic test_special_cases;
		add_header(KindBios, 1, 8'd1, 8'd1, 8'd1);
		add_strings("Z");
		add_header(KindBios, 0, 8'd1, 8'd1, 8'd1);
		add_strings("");
		add_header(8'h7F, 9, 8'd1, 8'd1, 8'd1);
		add_strings("q");
		add_header(KindBios, 9, 8'd0, 8'd5, 8'd2);
		add_strings("a/b");
		add_header(KindSystem, 6, 8'd1, 8'd2, 8'd0);
		add_strings("/p");
		add_header(KindSystem, 5, 8'd1, 8'd1, 8'd0);
		add_strings("k");
		send_table(0);
		wait_idle();
	endtask

	task automatic test_walk_limits;
		set_config(16'd12, 16'hFFFF);
		add_header(KindBios, 9, 8'd1, 8'd2, 8'd3);
		add_strings("Vendor/Ver/D");
		send_table(0);
		wait_idle();
		set_config(16'hFFFF, 16'd1);
		add_header(KindSystem, 6, 8'd1, 8'd2, 8'd0);
		add_strings("ab/c");
		add_header(KindBios, 9, 8'd1, 8'd1, 8'd1);
		add_strings("x");
		send_table(0);
		wait_idle();
		set_config(16'hFFFF, 16'd0);
		add_header(KindSystem, 6, 8'd1, 8'd1, 8'd0);
		add_strings("y");
		send_table(0);
		wait_idle();
		set_config(16'd0, 16'hFFFF);
		add_header(KindSystem, 6, 8'd1, 8'd1, 8'd0);
		add_strings("z");
		send_table(0);
		wait_idle();
	endtask

	task automatic test_truncation;
		set_config(16'hFFFF, 16'hFFFF);
		add_header(KindBios, 9, 8'd1, 8'd1, 8'd2);
		add_random_string(66);
		table_bytes.push_back(8'h00);
		send_table(0);
		wait_idle();
	endtask

	task automatic test_backpressure;
		calm = 1'b1;
		add_header(KindBios, 9, 8'd1, 8'd1, 8'd1);
		add_random_string(20);
		table_bytes.push_back(8'h00);
		fork
			begin
				hold_out <= 1'b1;
				repeat (300) @(posedge clk);
				hold_out <= 1'b0;
			end
			send_table(0);
		join
		wait_idle();
		calm = 1'b0;
	endtask

	task automatic test_random_tables;
		int table_no;
		int n_structs;
		int s;
		int k;
		int nstr;
		int flen;
		int total;
		int pick;
		logic [7:0] kind;
		logic [15:0] len_val;
		logic [15:0] cnt_val;
		table_no = 0;
		while (bytes_sent < 330) begin
			calm = (table_no >= 2 && table_no < 4);
			n_structs = $urandom_range(1, 5);
			for (s = 0; s < n_structs; s++) begin
				pick = $urandom_range(0, 99);
				kind = pick < 35 ? KindBios : pick < 70 ? KindSystem :
					8'($urandom_range(2, 255));
				pick = $urandom_range(0, 99);
				if (pick < 75) flen = (kind == KindBios) ? $urandom_range(9, 12) :
					$urandom_range(6, 10);
				else if (pick < 92) flen = $urandom_range(0, 8);
				else flen = $urandom_range(13, 40);
				add_header(kind, flen, 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(0, 4)));
				nstr = $urandom_range(0, 4);
				for (k = 0; k < nstr; k++)
					add_random_string(($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) :
						$urandom_range(1, 8));
				if (nstr == 0) table_bytes.push_back(8'h00);
				table_bytes.push_back(8'h00);
			end
			if ($urandom_range(0, 9) == 0)
				for (k = $urandom_range(1, 8); k > 0; k--)
					table_bytes.push_back(8'($urandom_range(0, 255)));
			total = table_bytes.size();
			pick = $urandom_range(0, 9);
			len_val = pick < 8 ? 16'(total) : pick < 9 ? 16'($urandom_range(1, total)) : 16'hFFFF;
			pick = $urandom_range(0, 9);
			cnt_val = pick < 8 ? 16'(n_structs) : pick < 9 ? 16'($urandom_range(0, n_structs)) :
				16'hFFFF;
			set_config(len_val, cnt_val);
			send_table(($urandom_range(0, 4) == 0) ? 2 : 0);
			wait_idle();
			table_no++;
		end
		calm = 1'b0;
	endtask

	initial begin
		clear_walk();
		table_len_cfg = '0;
		struct_cnt_cfg = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_bios_and_system();
		test_special_cases();
		test_walk_limits();
		test_truncation();
		test_backpressure();
		test_random_tables();
		repeat (8) @(posedge clk);
		$display("Walked %0d tables of %0d bytes in total, checking %0d output items,",
			tables_sent, bytes_sent, results_checked);
		$display("including truncation, walk limits, restarts and a long receiver stall.");
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("smbios_table_string_extractor_test OK");
		else
			$display("smbios_table_string_extractor_test NOT OK");
		$finish;
	end

endmodule
